>>> rtl/qtd_pkg.sv
// Shared types and constants of the Q-table TD update engine.
// Used by every module of the block but qtd_ram; depends on nothing.
package qtd_pkg;

  localparam int Q_W          = 32;
  localparam int FRAC_W       = 17;
  localparam int IN_STATE_W   = 5;
  localparam int IN_ACTION_W  = 3;
  localparam int CHANGE_W     = 31;
  localparam int CFG_IDX_W    = 2;
  localparam int STATE_CODES  = 2 ** IN_STATE_W;
  localparam int ACTION_CODES = 2 ** IN_ACTION_W;

  localparam int NUM_STATES_DEF  = 32;
  localparam int NUM_ACTIONS_DEF = 8;

  localparam logic [FRAC_W-1:0] ONE_Q16        = 17'd65536;
  localparam logic [FRAC_W-1:0] STEP_SIZE_RST  = 17'd52429;
  localparam logic [FRAC_W-1:0] DISCOUNT_RST   = 17'd58982;
  localparam logic signed [Q_W-1:0] FLOOR_Q16  = -32'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE = 2'd0,
    CFG_DISCOUNT  = 2'd1
  } qtd_cfg_idx_t;

  typedef struct packed {
    logic [IN_STATE_W-1:0]  prev_state;
    logic [IN_ACTION_W-1:0] taken_action;
    logic [IN_STATE_W-1:0]  next_state;
    logic signed [Q_W-1:0]  reward_value;
  } qtd_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] updated_value;
    logic [CHANGE_W-1:0]   change_size;
    logic signed [Q_W-1:0] next_row_max;
  } qtd_out_t;

  typedef struct packed {
    logic load;
    logic step;
  } qtd_scan_ctl_t;

  typedef struct packed {
    logic ld_gp;
    logic ld_td;
    logic ld_ad;
    logic ld_nv;
    logic ld_chg;
  } qtd_arith_ctl_t;

endpackage

>>> rtl/qtd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package needed.
module qtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/qtd_scan.sv
// Row maximum scanner: shifts a captured row out one entry per cycle while step is high.
// Depends on qtd_pkg for widths, the floor value and the control struct.
module qtd_scan #(
  parameter int NUM_ACTIONS = qtd_pkg::NUM_ACTIONS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  qtd_pkg::qtd_scan_ctl_t                 ctl,
  input  logic [NUM_ACTIONS*qtd_pkg::Q_W-1:0]    row_in,
  output logic signed [qtd_pkg::Q_W-1:0]         row_max,
  output logic                                   last
);
  import qtd_pkg::*;

  localparam int RW = NUM_ACTIONS * Q_W;
  localparam int AW = $clog2(NUM_ACTIONS);

  logic [RW-1:0]         row_r, row_nxt;
  logic signed [Q_W-1:0] max_r, max_nxt;
  logic [AW-1:0]         cnt_r, cnt_nxt;
  logic signed [Q_W-1:0] entry;

  assign entry = $signed(row_r[Q_W-1:0]);
  assign last  = (cnt_r == AW'(NUM_ACTIONS - 1));

  always_comb begin
    row_nxt = row_r;
    max_nxt = max_r;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      row_nxt = row_in;
      max_nxt = FLOOR_Q16;
      cnt_nxt = '0;
    end else if (ctl.step) begin
      row_nxt = row_r >> Q_W;
      cnt_nxt = cnt_r + AW'(1);
      if (entry > max_r) begin
        max_nxt = entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    row_r <= row_nxt;
    max_r <= max_nxt;
  end

  assign row_max = max_r;

endmodule

>>> rtl/qtd_arith.sv
// TD update arithmetic: gamma*max, TD error, alpha*TD, saturated new value and change.
// Depends on qtd_pkg for widths and the control struct.
module qtd_arith (
  input  logic                            clk,
  input  qtd_pkg::qtd_arith_ctl_t         ctl,
  input  logic [qtd_pkg::FRAC_W-1:0]      alpha,
  input  logic [qtd_pkg::FRAC_W-1:0]      gamma,
  input  logic signed [qtd_pkg::Q_W-1:0]  row_max,
  input  logic signed [qtd_pkg::Q_W-1:0]  reward,
  input  logic signed [qtd_pkg::Q_W-1:0]  old_value,
  output logic signed [qtd_pkg::Q_W-1:0]  new_value,
  output logic [qtd_pkg::CHANGE_W-1:0]    change
);
  import qtd_pkg::*;

  logic signed [49:0] gp_r, gp_nxt, gp_rnd;
  logic signed [33:0] gm;
  logic signed [35:0] td_r, td_nxt;
  logic signed [53:0] ad_r, ad_nxt, ad_rnd;
  logic signed [37:0] delta;
  logic signed [38:0] nv_full;
  logic signed [Q_W-1:0] nv_r, nv_nxt;
  logic signed [32:0] dif;
  logic [32:0] mag;
  logic [CHANGE_W-1:0] chg_r, chg_nxt;

  always_comb begin
    gp_nxt  = $signed({1'b0, gamma}) * row_max;
    gp_rnd  = gp_r + 50'sd32768;
    gm      = $signed(gp_rnd[49:16]);
    td_nxt  = {{4{reward[31]}}, reward} + {{2{gm[33]}}, gm}
              - {{4{old_value[31]}}, old_value};
    ad_nxt  = $signed({1'b0, alpha}) * td_r;
    ad_rnd  = ad_r + 54'sd32768;
    delta   = $signed(ad_rnd[53:16]);
    nv_full = {{7{old_value[31]}}, old_value} + {delta[37], delta};
    if (!nv_full[38] && (|nv_full[37:31])) begin
      nv_nxt = 32'sh7FFF_FFFF;
    end else if (nv_full[38] && !(&nv_full[37:31])) begin
      nv_nxt = -32'sh8000_0000;
    end else begin
      nv_nxt = nv_full[31:0];
    end
    dif = {nv_r[31], nv_r} - {old_value[31], old_value};
    mag = dif[32] ? 33'(-dif) : 33'(dif);
    if (|mag[32:31]) begin
      chg_nxt = {CHANGE_W{1'b1}};
    end else begin
      chg_nxt = mag[CHANGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_gp) begin
      gp_r <= gp_nxt;
    end
    if (ctl.ld_td) begin
      td_r <= td_nxt;
    end
    if (ctl.ld_ad) begin
      ad_r <= ad_nxt;
    end
    if (ctl.ld_nv) begin
      nv_r <= nv_nxt;
    end
    if (ctl.ld_chg) begin
      chg_r <= chg_nxt;
    end
  end

  assign new_value = nv_r;
  assign change    = chg_r;

endmodule

>>> rtl/q_table_td_update.sv
// Top level of the Q-table TD update engine: sequencer, registers and value table.
// Depends on qtd_pkg, qtd_ram, qtd_scan and qtd_arith.
//
//   channel   ports                                   handshake
//   input     start, busy, in_item                    taken when start && !busy
//   result    out_strobe, out_item                    valid for one cycle, no stall
//   config    cfg_we, cfg_index, cfg_data             written when cfg_we
//
// From acceptance to the next acceptance an item passes through two row reads on the
// single table read port, a scan of one row entry per cycle, two multiply steps, one TD
// sum step, one add and saturate step, one write-back of the row and the idle state in
// which the result is shown and the next item can be taken.
// After reset the table is cleared one row per cycle, all NUM_STATES rows, with busy high.
// The receiver cannot stall; each result is held for exactly one cycle.
module q_table_td_update #(
  parameter int NUM_STATES  = qtd_pkg::NUM_STATES_DEF,
  parameter int NUM_ACTIONS = qtd_pkg::NUM_ACTIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  qtd_pkg::qtd_in_t                in_item,
  output logic                            out_strobe,
  output qtd_pkg::qtd_out_t               out_item,
  input  logic                            cfg_we,
  input  logic [qtd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qtd_pkg::FRAC_W-1:0]      cfg_data
);
  import qtd_pkg::*;

  localparam int SW       = $clog2(NUM_STATES);
  localparam int AW       = $clog2(NUM_ACTIONS);
  localparam int RW       = NUM_ACTIONS * Q_W;
  localparam int ITEM_LAT = NUM_ACTIONS + 8;

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b00_0000_0001,
    ST_IDLE  = 10'b00_0000_0010,
    ST_RD1   = 10'b00_0000_0100,
    ST_RD2   = 10'b00_0000_1000,
    ST_SCAN  = 10'b00_0001_0000,
    ST_MULG  = 10'b00_0010_0000,
    ST_TD    = 10'b00_0100_0000,
    ST_MULA  = 10'b00_1000_0000,
    ST_WB    = 10'b01_0000_0000,
    ST_WR    = 10'b10_0000_0000
  } qtd_state_t;

  qtd_state_t state_r, state_nxt;

  logic [SW-1:0] state_map [STATE_CODES];
  logic [AW-1:0] action_map [ACTION_CODES];

  for (genvar g = 0; g < STATE_CODES; g++) begin : g_smap
    assign state_map[g] = SW'(g % NUM_STATES);
  end
  for (genvar g = 0; g < ACTION_CODES; g++) begin : g_amap
    assign action_map[g] = AW'(g % NUM_ACTIONS);
  end

  logic [FRAC_W-1:0] step_size_r, step_size_nxt;
  logic [FRAC_W-1:0] discount_r, discount_nxt;
  logic [FRAC_W-1:0] cfg_clamped;

  logic [SW-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic [SW-1:0]         prev_idx_r;
  logic [AW-1:0]         act_idx_r;
  logic signed [Q_W-1:0] reward_r;
  logic [RW-1:0]         prev_row_r;
  logic signed [Q_W-1:0] old_r;
  logic                  out_strobe_r, out_strobe_nxt;
  logic                  accept;

  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [SW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;
  logic [RW-1:0] wr_row;

  qtd_scan_ctl_t         scan_ctl;
  qtd_arith_ctl_t        arith_ctl;
  logic signed [Q_W-1:0] row_max;
  logic                  scan_last;
  logic signed [Q_W-1:0] new_value;
  logic [CHANGE_W-1:0]   change;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign cfg_clamped = (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;

  always_comb begin
    step_size_nxt = step_size_r;
    discount_nxt  = discount_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_SIZE: step_size_nxt = cfg_clamped;
        CFG_DISCOUNT:  discount_nxt  = cfg_clamped;
        default:       ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    out_strobe_nxt = 1'b0;
    scan_ctl       = '0;
    arith_ctl      = '0;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + SW'(1);
        if (clr_cnt_r == SW'(NUM_STATES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RD1;
        end
      end
      ST_RD1: begin
        scan_ctl.load = 1'b1;
        state_nxt     = ST_RD2;
      end
      ST_RD2: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        scan_ctl.step = 1'b1;
        if (scan_last) begin
          state_nxt = ST_MULG;
        end
      end
      ST_MULG: begin
        arith_ctl.ld_gp = 1'b1;
        state_nxt       = ST_TD;
      end
      ST_TD: begin
        arith_ctl.ld_td = 1'b1;
        state_nxt       = ST_MULA;
      end
      ST_MULA: begin
        arith_ctl.ld_ad = 1'b1;
        state_nxt       = ST_WB;
      end
      ST_WB: begin
        arith_ctl.ld_nv = 1'b1;
        state_nxt       = ST_WR;
      end
      ST_WR: begin
        arith_ctl.ld_chg = 1'b1;
        out_strobe_nxt   = 1'b1;
        state_nxt        = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  for (genvar j = 0; j < NUM_ACTIONS; j++) begin : g_wrow
    assign wr_row[j*Q_W +: Q_W] = (act_idx_r == AW'(j)) ? new_value
                                                       : prev_row_r[j*Q_W +: Q_W];
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = prev_idx_r;
    ram_wdata = wr_row;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (state_r == ST_WR) begin
      ram_we = 1'b1;
    end
    ram_raddr = (state_r == ST_IDLE) ? state_map[in_item.next_state] : prev_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
      step_size_r  <= STEP_SIZE_RST;
      discount_r   <= DISCOUNT_RST;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
      step_size_r  <= step_size_nxt;
      discount_r   <= discount_nxt;
    end
    if (accept) begin
      prev_idx_r <= state_map[in_item.prev_state];
      act_idx_r  <= action_map[in_item.taken_action];
      reward_r   <= in_item.reward_value;
    end
    if (state_r == ST_RD2) begin
      prev_row_r <= ram_rdata;
      old_r      <= $signed(ram_rdata[act_idx_r*Q_W +: Q_W]);
    end
  end

  qtd_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_STATES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  qtd_scan #(
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (scan_ctl),
    .row_in  (ram_rdata),
    .row_max (row_max),
    .last    (scan_last)
  );

  qtd_arith u_arith (
    .clk       (clk),
    .ctl       (arith_ctl),
    .alpha     (step_size_r),
    .gamma     (discount_r),
    .row_max   (row_max),
    .reward    (reward_r),
    .old_value (old_r),
    .new_value (new_value),
    .change    (change)
  );

  assign out_strobe             = out_strobe_r;
  assign out_item.updated_value = new_value;
  assign out_item.change_size   = change;
  assign out_item.next_row_max  = row_max;

  a_item_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##ITEM_LAT out_strobe)
    else $error("item result did not appear at the expected cycle");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while the engine is still busy");

endmodule

>>> test/testbench.sv
// Self-checking testbench for q_table_td_update: directed and random TD updates
// checked against a behavioral model of the value table. Depends on qtd_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import qtd_pkg::*;

  localparam int NS = NUM_STATES_DEF;
  localparam int NA = NUM_ACTIONS_DEF;
  localparam int LIMIT = 200000;
  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;
  localparam logic signed [Q_W-1:0] REWARD_MAX = 32'sh7fffffff;
  localparam logic signed [Q_W-1:0] REWARD_MIN = 32'sh80000000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_IDX = CFG_IDX_W'(2);

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  qtd_in_t in_item;
  logic out_strobe;
  qtd_out_t out_item;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FRAC_W-1:0] cfg_data;

  logic signed [Q_W-1:0] q_model [NS*NA];
  logic [FRAC_W-1:0] model_alpha;
  logic [FRAC_W-1:0] model_gamma;
  qtd_out_t pending_results[$];
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int settings_used = 0;
  int cycle_count = 0;

  q_table_td_update DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic qtd_out_t td_update(input qtd_in_t it);
    logic signed [Q_W-1:0] row_max, old_q, new_q, reward;
    longint gm, td, delta, nv, diff;
    int slot, row, j;
    qtd_out_t r;
    row = int'(it.next_state) % NS;
    row_max = FLOOR_Q16;
    for (j = 0; j < NA; j++)
      if (q_model[row*NA + j] > row_max) row_max = q_model[row*NA + j];
    slot = (int'(it.prev_state) % NS) * NA + int'(it.taken_action) % NA;
    old_q = q_model[slot];
    reward = it.reward_value;
    gm = (longint'(model_gamma) * longint'(row_max) + 64'sd32768) >>> 16;
    td = longint'(reward) + gm - longint'(old_q);
    delta = (longint'(model_alpha) * td + 64'sd32768) >>> 16;
    nv = longint'(old_q) + delta;
    if (nv > MAX32) nv = MAX32;
    else if (nv < MIN32) nv = MIN32;
    new_q = nv[Q_W-1:0];
    q_model[slot] = new_q;
    diff = nv - longint'(old_q);
    if (diff < 0) diff = -diff;
    if (diff > MAX32) diff = MAX32;
    r.updated_value = new_q;
    r.change_size = diff[CHANGE_W-1:0];
    r.next_row_max = row_max;
    return r;
  endfunction

  always @(posedge clk) begin
    qtd_out_t exp_r;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: updated_value %0d", out_item.updated_value);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        results_checked++;
        if (out_item.updated_value !== exp_r.updated_value) begin
          $error("updated_value: expected %0d, got %0d",
                 exp_r.updated_value, out_item.updated_value);
          error_count++;
        end
        if (out_item.change_size !== exp_r.change_size) begin
          $error("change_size: expected %0d, got %0d",
                 exp_r.change_size, out_item.change_size);
          error_count++;
        end
        if (out_item.next_row_max !== exp_r.next_row_max) begin
          $error("next_row_max: expected %0d, got %0d",
                 exp_r.next_row_max, out_item.next_row_max);
          error_count++;
        end
      end
    end
  end

  function automatic qtd_in_t make_item(input int prev, input int act, input int next,
                                        input logic signed [Q_W-1:0] reward);
    qtd_in_t it;
    it.prev_state = prev[IN_STATE_W-1:0];
    it.taken_action = act[IN_ACTION_W-1:0];
    it.next_state = next[IN_STATE_W-1:0];
    it.reward_value = reward;
    return it;
  endfunction

  function automatic qtd_in_t rand_item();
    qtd_in_t it;
    int sel, r;
    it.prev_state = IN_STATE_W'($urandom_range(1) ? $urandom_range(7)
                                                  : $urandom_range(STATE_CODES-1));
    it.taken_action = IN_ACTION_W'($urandom_range(ACTION_CODES-1));
    sel = $urandom_range(9);
    if (sel < 3) it.next_state = it.prev_state;
    else if (sel < 6) it.next_state = IN_STATE_W'($urandom_range(7));
    else it.next_state = IN_STATE_W'($urandom_range(STATE_CODES-1));
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3: begin
        r = int'($urandom_range(524288)) - 262144;
        it.reward_value = r;
      end
      4, 5, 6: it.reward_value = $urandom;
      7: it.reward_value = REWARD_MAX;
      8: it.reward_value = REWARD_MIN;
      default: it.reward_value = $urandom_range(2) - 1;
    endcase
    return it;
  endfunction

  function automatic int idle_gap(input int pct);
    return ($urandom_range(99) < pct) ? int'($urandom_range(1, 20)) : 0;
  endfunction

  task automatic send_item(input qtd_in_t it, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pending_results.push_back(td_update(it));
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(input qtd_cfg_idx_t idx, input int value);
    logic [FRAC_W-1:0] v;
    v = value[FRAC_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_STEP_SIZE) model_alpha = (v > ONE_Q16) ? ONE_Q16 : v;
    else model_gamma = (v > ONE_Q16) ? ONE_Q16 : v;
  endtask

  task automatic set_rates(input int alpha, input int gamma);
    wait_idle();
    write_reg(CFG_STEP_SIZE, alpha);
    write_reg(CFG_DISCOUNT, gamma);
    settings_used++;
  endtask

  task automatic test_default_settings();
    send_item(make_item(0, 0, 1, REWARD_MAX), 0);
    send_item(make_item(0, 0, 0, REWARD_MAX), 0);
    send_item(make_item(31, 7, 31, REWARD_MIN), 3);
    send_item(make_item(1, 3, 0, 0), 0);
    send_item(make_item(4, 2, 4, 1), 7);
  endtask

  task automatic test_row_floor();
    int a;
    set_rates(65536, 0);
    for (a = 0; a < NA; a++) send_item(make_item(5, a, 9, REWARD_MIN), 0);
    send_item(make_item(6, 0, 5, -32'sd196608), 0);
  endtask

  task automatic test_saturation();
    set_rates(65536, 65536);
    send_item(make_item(2, 0, 9, REWARD_MAX), 0);
    send_item(make_item(3, 0, 2, REWARD_MAX), 0);
    send_item(make_item(2, 0, 5, REWARD_MIN), 0);
  endtask

  task automatic test_unknown_register();
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_UNKNOWN_IDX;
    cfg_data <= '0;
    @(negedge clk);
    cfg_we <= 1'b0;
    send_item(make_item(8, 4, 8, 32'sd131072), 0);
    send_item(make_item(9, 5, 8, -32'sd65536), 0);
  endtask

  task automatic test_register_limits();
    set_rates(65537, 131071);
    send_item(make_item(7, 1, 0, 32'sd65536), 0);
    send_item(make_item(7, 1, 3, -32'sd65537), 2);
    set_rates(0, 0);
    send_item(make_item(0, 0, 3, REWARD_MAX), 0);
    send_item(make_item(3, 0, 0, REWARD_MIN), 0);
  endtask

  task automatic test_random_phases();
    int idle_pct [6];
    int p, n;
    idle_pct = '{0, 54, 33, 0, 54, 33};
    for (p = 0; p < 6; p++) begin
      case (p)
        0: set_rates($urandom_range(65536), $urandom_range(65536));
        1: set_rates(65536, 65536);
        2: set_rates(0, $urandom_range(65536));
        3: set_rates($urandom_range(65537, 131071), $urandom_range(65537, 131071));
        4: set_rates($urandom_range(65536), 0);
        default: set_rates($urandom_range(131071), $urandom_range(131071));
      endcase
      for (n = 0; n < 190; n++) send_item(rand_item(), idle_gap(idle_pct[p]));
    end
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_STEP_SIZE;
    cfg_data = '0;
    for (i = 0; i < NS*NA; i++) q_model[i] = '0;
    model_alpha = STEP_SIZE_RST;
    model_gamma = DISCOUNT_RST;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_default_settings();
    test_row_floor();
    test_saturation();
    test_unknown_register();
    test_register_limits();
    test_random_phases();

    wait_idle();
    repeat (NA + 8) @(posedge clk);
    $display("testbench: %0d items sent, %0d results checked, %0d rate settings",
             items_sent, results_checked, settings_used);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/qtd_pkg.sv
rtl/qtd_ram.sv
rtl/qtd_scan.sv
rtl/qtd_arith.sv
rtl/q_table_td_update.sv
test/testbench.sv
